FILE: src/tcw_pkg.sv
// tcw_pkg: shared constants, operation and character codes for the text console cell writer
// depends on nothing; used by tcw_sweep, the top level and the checker
`default_nettype none

package tcw_pkg;

  // default geometry
  localparam int COLUMNS_DEF  = 32;
  localparam int ROWS_DEF     = 16;
  localparam int TAB_SIZE_DEF = 8;

  // operation codes carried by func_i
  localparam logic [2:0] FUNC_WRITE    = 3'd0;
  localparam logic [2:0] FUNC_SETCUR   = 3'd1;
  localparam logic [2:0] FUNC_CLRALL   = 3'd2;
  localparam logic [2:0] FUNC_CLRLINE  = 3'd3;
  localparam logic [2:0] FUNC_READ     = 3'd4;
  localparam logic [2:0] FUNC_ACKROW   = 3'd5;
  localparam logic [2:0] FUNC_ACKSCR   = 3'd6;
  localparam logic [2:0] FUNC_SCROLL   = 3'd7;

  // control characters and the printable offset
  localparam logic [7:0] CHAR_BEL  = 8'h07;
  localparam logic [7:0] CHAR_BS   = 8'h08;
  localparam logic [7:0] CHAR_TAB  = 8'h09;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_BASE = 8'h20;

  // sweep unit command
  typedef struct packed {
    logic load;
    logic step;
  } sweep_cmd_t;

endpackage

`default_nettype wire

FILE: src/tcw_cell_mem.sv
// tcw_cell_mem: character cell store, one write port and one registered read port
// depends on nothing
`default_nettype none

module tcw_cell_mem #(
  parameter int AW    = 9,
  parameter int DEPTH = 512
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [7:0]    wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: src/tcw_sweep.sv
// tcw_sweep: shared address counter with end compare and row-ahead adder
// depends on tcw_pkg (sweep_cmd_t)
`default_nettype none

module tcw_sweep #(
  parameter int AW         = 9,
  parameter int STRIDE     = 32,
  parameter int RESET_LAST = 511
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tcw_pkg::sweep_cmd_t cmd_i,
  input  wire logic [AW-1:0]       first_i,
  input  wire logic [AW-1:0]       last_i,
  output logic      [AW-1:0]       addr_o,
  output logic      [AW-1:0]       ahead_o,
  output logic                     at_end_o
);

  logic [AW-1:0] addr_q, addr_d;
  logic [AW-1:0] last_q, last_d;

  // load a range or step through it
  always_comb begin
    addr_d = addr_q;
    last_d = last_q;
    if (cmd_i.load) begin
      addr_d = first_i;
      last_d = last_i;
    end else if (cmd_i.step) begin
      addr_d = addr_q + AW'(1);
    end
  end

  // reset starts the clearing pass over the whole store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
      last_q <= AW'(RESET_LAST);
    end else begin
      addr_q <= addr_d;
      last_q <= last_d;
    end
  end

  assign addr_o   = addr_q;
  assign ahead_o  = addr_q + AW'(STRIDE);
  assign at_end_o = (addr_q == last_q);

endmodule

`default_nettype wire

FILE: src/text_console_cell_writer_top.sv
// text_console_cell_writer_top: sequencer, cursor, dirty marks and result port
// depends on tcw_pkg, tcw_sweep, tcw_cell_mem
//
//  channel  | handshake            | fields
//  ---------+----------------------+------------------------------------------------
//  command  | start / busy         | func_i, code_in_i, column_in_i, row_in_i
//  result   | done_o (one cycle)   | cursor_column_o, cursor_row_o, glyph_out_o,
//           |                      | row_dirty_o, scroll_mark_o
//
//  An item is taken when start is high and busy low; busy stays high until the result cycle.
//  Tab, clear line and clear all zero cells one by one; a scroll copies every row up and then
//  clears the bottom row. It runs for the scroll operation and also from LF, wrap or set cursor.
//  The single memory port pair allows one cell to be written per cycle.
//  After reset a clearing pass over all COLUMNS*ROWS cells runs with busy high.
//  done_o is high for one cycle and the receiver cannot stall it.
`default_nettype none

module text_console_cell_writer_top #(
  parameter int COLUMNS  = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS     = tcw_pkg::ROWS_DEF,
  parameter int TAB_SIZE = tcw_pkg::TAB_SIZE_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] func_i,
  input  wire logic [7:0] code_in_i,
  input  wire logic [7:0] column_in_i,
  input  wire logic [7:0] row_in_i,
  output logic            done_o,
  output logic [4:0]      cursor_column_o,
  output logic [3:0]      cursor_row_o,
  output logic [7:0]      glyph_out_o,
  output logic            row_dirty_o,
  output logic            scroll_mark_o
);

  localparam int CW        = $clog2(COLUMNS);
  localparam int RW        = $clog2(ROWS);
  localparam int CELLS     = COLUMNS * ROWS;
  localparam int AW        = $clog2(CELLS);
  localparam int LAST      = CELLS - 1;
  localparam int COPY_LAST = (ROWS - 1) * COLUMNS - 1;
  localparam int LROW_BASE = (ROWS - 1) * COLUMNS;

  localparam logic [AW-1:0] COL_STEP  = AW'(COLUMNS);
  localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
  localparam logic [CW-1:0] COL_PREV  = CW'(COLUMNS - 2);
  localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);

  // sequencer states
  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_EXEC  = 4'd2;
  localparam logic [3:0] S_READ  = 4'd3;
  localparam logic [3:0] S_CLR   = 4'd4;
  localparam logic [3:0] S_COPY  = 4'd5;
  localparam logic [3:0] S_DRAIN = 4'd6;
  localparam logic [3:0] S_TAB   = 4'd7;
  localparam logic [3:0] S_BSW   = 4'd8;

  logic [3:0]      state_q, state_d;
  logic [2:0]      func_q, func_d;
  logic [7:0]      code_q, code_d;
  logic [7:0]      col_in_q, col_in_d;
  logic [7:0]      row_in_q, row_in_d;
  logic [CW-1:0]   cur_col_q, cur_col_d;
  logic [RW-1:0]   cur_row_q, cur_row_d;
  logic [ROWS-1:0] dirty_q, dirty_d;
  logic            scrolled_q, scrolled_d;
  logic [7:0]      glyph_q, glyph_d;
  logic            rdirty_q, rdirty_d;
  logic            done_q, done_d;
  logic [AW-1:0]   wa_q, wa_d;
  logic            pend_q, pend_d;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [7:0]          mem_wdata;
  logic [AW-1:0]       mem_raddr;
  logic [7:0]          mem_rdata;

  tcw_pkg::sweep_cmd_t sw_cmd;
  logic [AW-1:0]       sw_first;
  logic [AW-1:0]       sw_last;
  logic [AW-1:0]       sw_addr;
  logic [AW-1:0]       sw_ahead;
  logic                sw_at_end;

  logic                accept;
  logic                row_ok;
  logic                col_ok;
  logic [RW-1:0]       in_row;
  logic [AW-1:0]       cur_addr;
  logic [AW-1:0]       in_addr;
  logic [AW-1:0]       in_row_base;
  logic [COLUMNS-1:0]  tab_stop;

  logic [7:0]          sc_x;
  logic [8:0]          sc_y;
  logic                sc_scroll;
  logic [CW-1:0]       sc_col;
  logic [RW-1:0]       sc_row;

  logic                go_scroll;
  logic                go_finish;
  logic [7:0]          col_wide;
  logic [7:0]          row_wide;

  // shared address unit
  tcw_sweep #(
    .AW         (AW),
    .STRIDE     (COLUMNS),
    .RESET_LAST (LAST)
  ) u_sweep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (sw_cmd),
    .first_i  (sw_first),
    .last_i   (sw_last),
    .addr_o   (sw_addr),
    .ahead_o  (sw_ahead),
    .at_end_o (sw_at_end)
  );

  // cell store
  tcw_cell_mem #(
    .AW    (AW),
    .DEPTH (CELLS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // tab stop marks: bit i set when column i+1 is a multiple of the tab size
  for (genvar gi = 0; gi < COLUMNS; gi++) begin : g_tab
    assign tab_stop[gi] = (((gi + 1) % TAB_SIZE) == 0);
  end

  assign accept = start && !busy;

  // range checks and addresses of the requested cell
  assign row_ok      = !row_in_q[7] && (row_in_q < 8'(ROWS));
  assign col_ok      = !col_in_q[7] && (col_in_q < 8'(COLUMNS));
  assign in_row      = row_in_q[RW-1:0];
  assign in_row_base = AW'(in_row) * COL_STEP;
  assign in_addr     = in_row_base + AW'(col_in_q[CW-1:0]);
  assign cur_addr    = AW'(cur_row_q) * COL_STEP + AW'(cur_col_q);

  // cursor placement for set cursor
  always_comb begin
    if (row_in_q[7]) begin
      sc_x = '0;
      sc_y = '0;
    end else begin
      sc_x = col_in_q[7] ? 8'd0 : col_in_q;
      sc_y = {1'b0, row_in_q};
      if (sc_x > 8'(COLUMNS - 1)) begin
        sc_x = '0;
        sc_y = sc_y + 9'd1;
      end
    end
    sc_scroll = (sc_y > 9'(ROWS - 1));
    sc_col    = sc_x[CW-1:0];
    sc_row    = sc_scroll ? ROW_LAST : sc_y[RW-1:0];
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    func_d     = func_q;
    code_d     = code_q;
    col_in_d   = col_in_q;
    row_in_d   = row_in_q;
    cur_col_d  = cur_col_q;
    cur_row_d  = cur_row_q;
    dirty_d    = dirty_q;
    scrolled_d = scrolled_q;
    glyph_d    = glyph_q;
    rdirty_d   = rdirty_q;
    done_d     = 1'b0;
    wa_d       = wa_q;
    pend_d     = pend_q;
    mem_we     = 1'b0;
    mem_waddr  = sw_addr;
    mem_wdata  = '0;
    mem_raddr  = sw_ahead;
    sw_cmd     = '0;
    sw_first   = '0;
    sw_last    = '0;
    go_scroll  = 1'b0;
    go_finish  = 1'b0;

    unique case (state_q)
      // clearing pass after reset
      S_INIT: begin
        mem_we = 1'b1;
        if (sw_at_end) begin
          state_d = S_IDLE;
        end else begin
          sw_cmd.step = 1'b1;
        end
      end

      S_IDLE: begin
        if (accept) begin
          func_d   = func_i;
          code_d   = code_in_i;
          col_in_d = column_in_i;
          row_in_d = row_in_i;
          glyph_d  = '0;
          rdirty_d = 1'b0;
          state_d  = S_EXEC;
        end
      end

      S_EXEC: begin
        unique case (func_q)
          tcw_pkg::FUNC_WRITE: begin
            dirty_d[cur_row_q] = 1'b1;
            unique case (code_q)
              tcw_pkg::CHAR_CR: begin
                cur_col_d = '0;
                go_finish = 1'b1;
              end
              tcw_pkg::CHAR_LF: begin
                if (cur_row_q == ROW_LAST) begin
                  go_scroll = 1'b1;
                end else begin
                  cur_row_d = cur_row_q + RW'(1);
                  go_finish = 1'b1;
                end
              end
              tcw_pkg::CHAR_TAB: begin
                if (cur_col_q == COL_LAST) begin
                  go_finish = 1'b1;
                end else begin
                  state_d = S_TAB;
                end
              end
              tcw_pkg::CHAR_BS: begin
                if (cur_col_q != '0) begin
                  cur_col_d = cur_col_q - CW'(1);
                end
                state_d = S_BSW;
              end
              tcw_pkg::CHAR_BEL: begin
                go_finish = 1'b1;
              end
              default: begin
                mem_we    = 1'b1;
                mem_waddr = cur_addr;
                mem_wdata = code_q - tcw_pkg::CHAR_BASE;
                if (cur_col_q == COL_LAST) begin
                  cur_col_d = '0;
                  if (cur_row_q == ROW_LAST) begin
                    go_scroll = 1'b1;
                  end else begin
                    cur_row_d = cur_row_q + RW'(1);
                    go_finish = 1'b1;
                  end
                end else begin
                  cur_col_d = cur_col_q + CW'(1);
                  go_finish = 1'b1;
                end
              end
            endcase
          end
          tcw_pkg::FUNC_SETCUR: begin
            cur_col_d = sc_col;
            cur_row_d = sc_row;
            go_scroll = sc_scroll;
            go_finish = !sc_scroll;
          end
          tcw_pkg::FUNC_CLRALL: begin
            dirty_d         = '1;
            sw_cmd.load     = 1'b1;
            sw_first        = '0;
            sw_last         = AW'(LAST);
            state_d         = S_CLR;
          end
          tcw_pkg::FUNC_CLRLINE: begin
            if (row_ok) begin
              dirty_d[in_row] = 1'b1;
              sw_cmd.load     = 1'b1;
              sw_first        = in_row_base;
              sw_last         = in_row_base + COL_STEP - AW'(1);
              state_d         = S_CLR;
            end else begin
              go_finish = 1'b1;
            end
          end
          tcw_pkg::FUNC_READ: begin
            if (row_ok) begin
              rdirty_d = dirty_q[in_row];
            end
            mem_raddr = in_addr;
            state_d   = S_READ;
          end
          tcw_pkg::FUNC_ACKROW: begin
            if (row_ok) begin
              dirty_d[in_row] = 1'b0;
            end
            go_finish = 1'b1;
          end
          tcw_pkg::FUNC_ACKSCR: begin
            scrolled_d = 1'b0;
            go_finish  = 1'b1;
          end
          default: begin
            go_scroll = 1'b1;
          end
        endcase
      end

      // cell data from the registered read arrives in the cycle after the read
      S_READ: begin
        glyph_d   = (row_ok && col_ok) ? mem_rdata : 8'd0;
        go_finish = 1'b1;
      end

      // zero a range of cells
      S_CLR: begin
        mem_we = 1'b1;
        if (sw_at_end) begin
          go_finish = 1'b1;
        end else begin
          sw_cmd.step = 1'b1;
        end
      end

      // move each cell up one row: read one row ahead, write it in the next cycle
      S_COPY: begin
        mem_raddr = sw_ahead;
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = wa_q;
          mem_wdata = mem_rdata;
        end
        wa_d   = sw_addr;
        pend_d = 1'b1;
        if (sw_at_end) begin
          state_d = S_DRAIN;
        end else begin
          sw_cmd.step = 1'b1;
        end
      end

      // last copied cell, then clear the bottom row
      S_DRAIN: begin
        mem_we      = 1'b1;
        mem_waddr   = wa_q;
        mem_wdata   = mem_rdata;
        pend_d      = 1'b0;
        sw_cmd.load = 1'b1;
        sw_first    = AW'(LROW_BASE);
        sw_last     = AW'(LAST);
        state_d     = S_CLR;
      end

      // zero cells up to the next tab stop, short of the last column
      S_TAB: begin
        mem_we    = 1'b1;
        mem_waddr = cur_addr;
        cur_col_d = cur_col_q + CW'(1);
        if (tab_stop[cur_col_q] || (cur_col_q == COL_PREV)) begin
          go_finish = 1'b1;
        end
      end

      // backspace clears the cell it lands on
      S_BSW: begin
        mem_we    = 1'b1;
        mem_waddr = cur_addr;
        go_finish = 1'b1;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // start of a scroll: all rows dirty, then copy
    if (go_scroll) begin
      dirty_d     = '1;
      scrolled_d  = 1'b1;
      pend_d      = 1'b0;
      sw_cmd.load = 1'b1;
      sw_first    = '0;
      sw_last     = AW'(COPY_LAST);
      state_d     = S_COPY;
    end

    if (go_finish) begin
      state_d = S_IDLE;
      done_d  = 1'b1;
    end
  end

  // control and cursor registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_INIT;
      cur_col_q  <= '0;
      cur_row_q  <= '0;
      dirty_q    <= '0;
      scrolled_q <= 1'b0;
      done_q     <= 1'b0;
      pend_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      cur_col_q  <= cur_col_d;
      cur_row_q  <= cur_row_d;
      dirty_q    <= dirty_d;
      scrolled_q <= scrolled_d;
      done_q     <= done_d;
      pend_q     <= pend_d;
    end
  end

  // item and result payload registers
  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    code_q   <= code_d;
    col_in_q <= col_in_d;
    row_in_q <= row_in_d;
    glyph_q  <= glyph_d;
    rdirty_q <= rdirty_d;
    wa_q     <= wa_d;
  end

  // result port
  assign col_wide        = 8'(cur_col_q);
  assign row_wide        = 8'(cur_row_q);
  assign busy            = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign cursor_column_o = col_wide[4:0];
  assign cursor_row_o    = row_wide[3:0];
  assign glyph_out_o     = glyph_q;
  assign row_dirty_o     = rdirty_q;
  assign scroll_mark_o   = scrolled_q;

endmodule

`default_nettype wire

FILE: src/tcw_checker.sv
// tcw_checker: port-level checks on the text console cell writer, bound to the top level
// depends on tcw_pkg (operation codes) and text_console_cell_writer_top
`default_nettype none

module tcw_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [2:0] func_i,
  input wire logic       done_o,
  input wire logic       scroll_mark_o
);

  // a result is only shown once the block is free again
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  // a taken item keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("not busy after item taken");

  // no result in the cycle right after an item is taken
  a_accept_no_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !done_o)
    else $error("result too early");

  // a scroll ack goes through the execute state and then shows its result with the mark cleared
  a_ackscr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (func_i == tcw_pkg::FUNC_ACKSCR)) |=> ##1 (done_o && !scroll_mark_o))
    else $error("scroll ack result wrong");

endmodule

bind text_console_cell_writer_top tcw_checker u_tcw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .func_i        (func_i),
  .done_o        (done_o),
  .scroll_mark_o (scroll_mark_o)
);

`default_nettype wire
